// File: hw/rtl/ktg_pkg.sv
package ktg_pkg;

   // Configuration register indexes.
   localparam logic CSR_WAVE_MODE = 1'b0;
   localparam logic CSR_AMPLITUDE = 1'b1;

   localparam int AMP_BITS    = 15;
   localparam int SAMPLE_BITS = 16;
   localparam int KEY_BITS    = 7;
   localparam int KEY_COUNT   = 88;

   localparam logic [AMP_BITS-1:0] AMPLITUDE_RESET = 15'd3000;

   // Waveform select codes.
   localparam logic WAVE_SINE   = 1'b0;
   localparam logic WAVE_SQUARE = 1'b1;

   // Pi/2 in Q30.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Pitches of keys 1..12 in Hz, unsigned Q24.
   localparam logic [31:0] BASE_PITCH_Q24 [12] = '{
      32'd461373440, 32'd488808132, 32'd517874176, 32'd548668578,
      32'd581294109, 32'd615859655, 32'd652480576, 32'd691279090,
      32'd732384684, 32'd775932866, 32'd822074013, 32'd870957077
   };

   // Divisors (2k)(2k+1) of the sine Taylor series terms.
   localparam logic [63:0] TAYLOR_DIV [1:8] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
   };

endpackage

// File: hw/rtl/key_tone_generator_top.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   req_key_number[6:0], req_note_start
// rsp_      out        rsp_valid / rsp_stall   rsp_sample_value[15:0] signed
// csr_      in         csr_write               csr_index, csr_data[14:0]
//
// One item is accepted per cycle unless req_stall is high; its sample passes
// through the sine memory read register, then the amplitude multiply into the
// output register. After reset the sine memory is loaded by a sweep that writes
// all 2^TABLE_BITS + 1 entries (1025 at the default) while req_stall is high;
// csr writes still land. A stalled rsp_ holds the output register, and outside
// the load sweep the input is stalled only when the memory-read stage is also full.
module key_tone_generator_top #(
   parameter int SAMPLE_RATE = 44100,
   parameter int PHASE_BITS  = 32,
   parameter int TABLE_BITS  = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ktg_pkg::KEY_BITS-1:0]      req_key_number,
   input  logic                              req_note_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ktg_pkg::SAMPLE_BITS-1:0] rsp_sample_value,
   input  logic                              csr_write,
   input  logic                              csr_index,
   input  logic [ktg_pkg::AMP_BITS-1:0]      csr_data
);
   import ktg_pkg::*;

   localparam int TBL_SIZE  = 1 << TABLE_BITS;
   localparam int ROM_DEPTH = TBL_SIZE + 1;
   localparam int ADDR_BITS = TABLE_BITS + 1;

   // Phase increment = round(f_Q24 * 2^PHASE_BITS / (SAMPLE_RATE * 2^24)).
   localparam int INC_UP = (PHASE_BITS >= 24) ? PHASE_BITS - 24 : 0;
   localparam int INC_DN = (PHASE_BITS < 24) ? 24 - PHASE_BITS : 0;
   localparam logic [63:0] INC_DEN = 64'(SAMPLE_RATE) << INC_DN;

   typedef logic [AMP_BITS-1:0]   sine_rom_type [ROM_DEPTH];
   typedef logic [PHASE_BITS-1:0] inc_rom_type  [KEY_COUNT];

   // Quarter-wave sine in unsigned Q0.15 from a Q30 Taylor series, worked out at
   // elaboration.
   function automatic sine_rom_type build_sine();
      sine_rom_type      rom;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       term;
      logic signed [63:0] sum;
      logic signed [63:0] q;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         x    = (64'(i) * HALF_PI_Q30 + 64'(TBL_SIZE / 2)) >> TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = signed'(x);
         for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k % 2 == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         q = (sum + 64'sd16384) >>> 15;
         if (q > 64'sd32767) begin
            q = 64'sd32767;
         end
         rom[i] = AMP_BITS'(q);
      end
      return rom;
   endfunction

   function automatic inc_rom_type build_inc();
      inc_rom_type rom;
      logic [63:0] num;
      for (int i = 0; i < KEY_COUNT; i++) begin
         num    = (64'(BASE_PITCH_Q24[i % 12]) << (i / 12)) << INC_UP;
         rom[i] = PHASE_BITS'((num + INC_DEN / 2) / INC_DEN);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();
   localparam inc_rom_type  KEY_INC  = build_inc();

   // Configuration registers.
   logic                wave_mode_ff, wave_mode_in;
   logic [AMP_BITS-1:0] amplitude_ff, amplitude_in;

   always_comb begin
      wave_mode_in = wave_mode_ff;
      amplitude_in = amplitude_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_WAVE_MODE: wave_mode_in = csr_data[0];
            CSR_AMPLITUDE: amplitude_in = csr_data;
            default: ;
         endcase
      end
   end

   // Sine memory load sweep after reset.
   logic                 filling_ff, filling_in;
   logic [ADDR_BITS-1:0] fill_cnt_ff, fill_cnt_in;

   always_comb begin
      filling_in  = filling_ff;
      fill_cnt_in = fill_cnt_ff;
      if (filling_ff) begin
         fill_cnt_in = fill_cnt_ff + 1'b1;
         if (fill_cnt_ff == ADDR_BITS'(TBL_SIZE)) begin
            filling_in = 1'b0;
         end
      end
   end

   // Pipeline control. Stage 1 waits on the memory read, stage 2 is the
   // output register.
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_free, s1_ready, accept;

   assign s2_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || s2_free;
   assign req_stall = filling_ff || !s1_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s2_free) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   // Phase accumulator. The sample is taken from the phase before the step.
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] phase_cur;
   logic [KEY_BITS-1:0]   key_idx;
   logic [1:0]            quad;
   logic [TABLE_BITS-1:0] tab_j;
   logic [ADDR_BITS-1:0]  rd_addr;

   always_comb begin
      if (req_key_number == '0) begin
         key_idx = '0;
      end else if (req_key_number > KEY_BITS'(KEY_COUNT)) begin
         key_idx = KEY_BITS'(KEY_COUNT - 1);
      end else begin
         key_idx = req_key_number - 1'b1;
      end
      phase_cur = req_note_start ? '0 : phase_ff;
      phase_in  = accept ? phase_cur + KEY_INC[key_idx] : phase_ff;
      quad      = phase_cur[PHASE_BITS-1 -: 2];
      tab_j     = phase_cur[PHASE_BITS-3 -: TABLE_BITS];
      // Odd quadrants read the quarter wave backwards.
      rd_addr   = quad[0] ? ADDR_BITS'(TBL_SIZE) - {1'b0, tab_j} : {1'b0, tab_j};
   end

   logic [AMP_BITS-1:0] sine_rd;

   ktg_ram #(
      .WIDTH (AMP_BITS),
      .DEPTH (ROM_DEPTH)
   ) u_sine_ram (
      .clock   (clock),
      .wr_en   (filling_ff),
      .wr_addr (fill_cnt_ff),
      .wr_data (SINE_ROM[fill_cnt_ff]),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (sine_rd)
   );

   // Stage 1 payload: sign of the sine half and the square-wave half.
   logic s1_neg_ff, s1_neg_in;

   assign s1_neg_in = accept ? phase_cur[PHASE_BITS-1] : s1_neg_ff;

   // Stage 2: scale by amplitude, truncate toward zero (square mode takes the amplitude as is), then apply the sign.
   logic [2*AMP_BITS-1:0]         product;
   logic [SAMPLE_BITS-1:0]        magnitude;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;

   always_comb begin
      product = amplitude_ff * sine_rd;
      if (wave_mode_ff == WAVE_SQUARE) begin
         magnitude = {1'b0, amplitude_ff};
      end else begin
         magnitude = {1'b0, product[2*AMP_BITS-1 -: AMP_BITS]};
      end
      sample_in = sample_ff;
      if (s2_free && s1_valid_ff) begin
         sample_in = s1_neg_ff ? -signed'(magnitude) : signed'(magnitude);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff <= WAVE_SINE;
         amplitude_ff <= AMPLITUDE_RESET;
         filling_ff   <= 1'b1;
         fill_cnt_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
      end else begin
         wave_mode_ff <= wave_mode_in;
         amplitude_ff <= amplitude_in;
         filling_ff   <= filling_in;
         fill_cnt_ff  <= fill_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_neg_ff <= s1_neg_in;
      sample_ff <= sample_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = sample_ff;

endmodule

// File: hw/rtl/ktg_ram.sv
module ktg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
